// ----- rtl/ubxp_pkg.sv -----
// Package for the UBX navigation frame parser: phase encoding, sync
// constants, register indexes, configuration and result structs.
// No dependencies; the frame FSM, the top level and the testbench import it.
package ubxp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  localparam logic [7:0] ResetWantClass  = 8'h01;
  localparam logic [7:0] ResetWantId     = 8'h07;
  localparam int         LengthW         = 10;
  localparam logic [LengthW-1:0] ResetWantLength = 10'd92;

  // Payload bytes 4 to 11 carry the UTC date, time and validity flags.
  localparam int CapFirst = 4;
  localparam int CapCount = 8;
  localparam int CapIdxW  = $clog2(CapCount);

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = LengthW;
  localparam logic [CfgIndexW-1:0] CfgWantClass  = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgWantId     = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgWantLength = 2'd2;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } ubxp_phase_t;

  typedef struct packed {
    logic [7:0]         want_class;
    logic [7:0]         want_id;
    logic [LengthW-1:0] want_length;
  } ubxp_cfg_t;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic        date_valid;
    logic        time_valid;
    logic        fully_resolved;
    logic        utc_valid;
  } ubxp_utc_t;

endpackage

// ----- rtl/ubxp_if.sv -----
// Stream interfaces of the UBX frame parser: the received byte channel and
// the UTC result channel, each with valid, ready and payload.
// No dependencies.
interface ubxp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxp_utc_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  logic        date_valid;
  logic        time_valid;
  logic        fully_resolved;
  logic        utc_valid;

  modport source (
    output valid, output year, output month, output day, output hour,
    output minute, output second, output date_valid, output time_valid,
    output fully_resolved, output utc_valid, input ready
  );
  modport sink (
    input valid, input year, input month, input day, input hour,
    input minute, input second, input date_valid, input time_valid,
    input fully_resolved, input utc_valid, output ready
  );
endinterface

// ----- rtl/ubxp_frame_fsm.sv -----
// Frame state machine of the UBX parser: sync hunt, header, Fletcher-8
// checksum, payload capture and the final match, one byte per beat.
// Depends on ubxp_pkg.
module ubxp_frame_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  ubxp_pkg::ubxp_cfg_t cfg,
  output logic                hit,
  output ubxp_pkg::ubxp_utc_t result
);
  import ubxp_pkg::*;

  ubxp_phase_t        phase, phase_next;
  logic [7:0]         frame_class, frame_class_next;
  logic [7:0]         frame_id, frame_id_next;
  logic [15:0]        declared_length, declared_length_next;
  logic [LengthW-1:0] payload_position, payload_position_next;
  logic [7:0]         sum_a, sum_a_next;
  logic [7:0]         sum_b, sum_b_next;
  logic [7:0]         got_sum_a, got_sum_a_next;
  logic [7:0]         captured [CapCount];

  logic [7:0]         sum_a_add;
  logic [7:0]         sum_b_add;
  logic [15:0]        length_full;
  logic [LengthW-1:0] position_inc;
  logic [LengthW-1:0] cap_offset;
  logic               cap_we;
  logic [CapIdxW-1:0] cap_idx;
  logic               frame_match;

  assign sum_a_add    = sum_a + rx_byte;
  assign sum_b_add    = sum_b + sum_a_add;
  assign length_full  = {rx_byte, declared_length[7:0]};
  assign position_inc = payload_position + LengthW'(1);
  assign cap_offset   = payload_position - LengthW'(CapFirst);
  assign cap_idx      = cap_offset[CapIdxW-1:0];
  assign cap_we       = byte_valid && (phase == PH_PAYLOAD) &&
                        (payload_position >= LengthW'(CapFirst)) &&
                        (payload_position < LengthW'(CapFirst + CapCount));

  // Next state.
  always_comb begin
    phase_next            = phase;
    frame_class_next      = frame_class;
    frame_id_next         = frame_id;
    declared_length_next  = declared_length;
    payload_position_next = payload_position;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    got_sum_a_next        = got_sum_a;
    if (byte_valid) begin
      unique case (phase)
        PH_SYNC2: begin
          if (rx_byte == SyncSecond) begin
            sum_a_next = 8'd0;
            sum_b_next = 8'd0;
            phase_next = PH_CLASS;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          frame_class_next = rx_byte;
          sum_a_next       = sum_a_add;
          sum_b_next       = sum_b_add;
          phase_next       = PH_ID;
        end
        PH_ID: begin
          frame_id_next = rx_byte;
          sum_a_next    = sum_a_add;
          sum_b_next    = sum_b_add;
          phase_next    = PH_LEN1;
        end
        PH_LEN1: begin
          declared_length_next = {8'd0, rx_byte};
          sum_a_next           = sum_a_add;
          sum_b_next           = sum_b_add;
          phase_next           = PH_LEN2;
        end
        PH_LEN2: begin
          declared_length_next  = length_full;
          sum_a_next            = sum_a_add;
          sum_b_next            = sum_b_add;
          payload_position_next = '0;
          priority if (length_full > {6'd0, cfg.want_length}) begin
            phase_next = PH_SYNC1;
          end else if (length_full == 16'd0) begin
            phase_next = PH_CKA;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_next            = sum_a_add;
          sum_b_next            = sum_b_add;
          payload_position_next = position_inc;
          if ({6'd0, position_inc} >= declared_length) begin
            phase_next = PH_CKA;
          end
        end
        PH_CKA: begin
          got_sum_a_next = rx_byte;
          phase_next     = PH_CKB;
        end
        PH_CKB: begin
          phase_next = PH_SYNC1;
        end
        default: begin
          phase_next = (rx_byte == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  // Outputs: a result is due on the second checksum byte of a matching frame.
  always_comb begin
    frame_match = (got_sum_a == sum_a) && (rx_byte == sum_b) &&
                  (frame_class == cfg.want_class) && (frame_id == cfg.want_id) &&
                  (declared_length == {6'd0, cfg.want_length});
    hit = byte_valid && (phase == PH_CKB) && frame_match;
    result.year           = {captured[1], captured[0]};
    result.month          = captured[2];
    result.day            = captured[3];
    result.hour           = captured[4];
    result.minute         = captured[5];
    result.second         = captured[6];
    result.date_valid     = captured[7][0];
    result.time_valid     = captured[7][1];
    result.fully_resolved = captured[7][2];
    result.utc_valid      = captured[7][0] & captured[7][1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC1;
      frame_class      <= '0;
      frame_id         <= '0;
      declared_length  <= '0;
      payload_position <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
      got_sum_a        <= '0;
    end else begin
      phase            <= phase_next;
      frame_class      <= frame_class_next;
      frame_id         <= frame_id_next;
      declared_length  <= declared_length_next;
      payload_position <= payload_position_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      got_sum_a        <= got_sum_a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      captured[cap_idx] <= rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_payload_length_bounded : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (declared_length != 16'd0) &&
                              (declared_length[15:LengthW] == '0))
    else $error("payload phase with an impossible declared length");

  a_position_below_length : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> ({6'd0, payload_position} < declared_length))
    else $error("payload position ran past the declared length");

  a_hunt_after_checksum : assert property (@(posedge clk) disable iff (rst)
    (byte_valid && (phase == PH_CKB)) |=> (phase == PH_SYNC1))
    else $error("parser did not return to hunting after a frame");
`endif

endmodule

// ----- rtl/ubx_nav_pvt_frame_parser_unit.sv -----
// Top level of the UBX navigation frame parser: configuration registers,
// stream handshake and result register. Depends on ubxp_pkg, ubxp_if and
// ubxp_frame_fsm.
//
// The unit takes one received serial byte per beat on rx and reports the
// UTC date, time and validity flags of each frame that carries the
// configured class, id and payload length and whose two Fletcher-8
// checksum bytes match. Every byte is handled on the beat that accepts it, so the
// unit accepts a byte in every clock cycle; the only thing that holds rx
// back is a result sitting in the output register that the utc side has
// not yet taken. The result appears on utc in the cycle after the second
// checksum byte is accepted. Frames that fail a check produce nothing, and
// a declared length above want_length abandons the frame right after the
// length field. The registers want_class, want_id and want_length reset to
// 1, 7 and 92 and are written through cfg_wr_en, cfg_index and cfg_data;
// they should be written only while no frame is in flight. With
// want_length below twelve, a reported frame shows captured payload bytes
// from earlier frames, which are meaningless until such a frame arrived.
module ubx_nav_pvt_frame_parser_unit (
  input  logic                           clk,
  input  logic                           rst,
  ubxp_rx_if.sink                        rx,
  ubxp_utc_if.source                     utc,
  input  logic                           cfg_wr_en,
  input  logic [ubxp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ubxp_pkg::CfgDataW-1:0]  cfg_data
);
  import ubxp_pkg::*;

  ubxp_cfg_t cfg;
  logic      accept;
  logic      hit;
  ubxp_utc_t result;
  logic      out_valid;
  ubxp_utc_t out_data;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.want_class  <= ResetWantClass;
      cfg.want_id     <= ResetWantId;
      cfg.want_length <= ResetWantLength;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgWantClass:  cfg.want_class  <= cfg_data[7:0];
        CfgWantId:     cfg.want_id     <= cfg_data[7:0];
        CfgWantLength: cfg.want_length <= cfg_data[LengthW-1:0];
        default: ;
      endcase
    end
  end

  // The output register separates the two sides: a new byte is taken
  // whenever the register is empty or is being drained in this cycle.
  assign rx.ready = !out_valid || utc.ready;
  assign accept   = rx.valid && rx.ready;

  ubxp_frame_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept),
    .rx_byte    (rx.rx_byte),
    .cfg        (cfg),
    .hit        (hit),
    .result     (result)
  );

  // A result is loaded only on the beat that completes a matching frame;
  // since that beat also requires room in the register, nothing is lost.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && hit) begin
      out_valid <= 1'b1;
    end else if (utc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      out_data <= result;
    end
  end

  assign utc.valid          = out_valid;
  assign utc.year           = out_data.year;
  assign utc.month          = out_data.month;
  assign utc.day            = out_data.day;
  assign utc.hour           = out_data.hour;
  assign utc.minute         = out_data.minute;
  assign utc.second         = out_data.second;
  assign utc.date_valid     = out_data.date_valid;
  assign utc.time_valid     = out_data.time_valid;
  assign utc.fully_resolved = out_data.fully_resolved;
  assign utc.utc_valid      = out_data.utc_valid;

`ifndef SYNTHESIS
  a_result_follows_byte : assert property (@(posedge clk) disable iff (rst)
    $rose(utc.valid) |-> $past(rx.valid && rx.ready))
    else $error("result appeared without an accepted byte");

  a_result_not_dropped : assert property (@(posedge clk) disable iff (rst)
    $fell(utc.valid) |-> $past(utc.ready))
    else $error("pending result vanished before it was taken");

  a_utc_flag_consistent : assert property (@(posedge clk) disable iff (rst)
    utc.valid |-> (utc.utc_valid == (utc.date_valid && utc.time_valid)))
    else $error("utc_valid disagrees with the date and time flags");
`endif

endmodule

// ----- tb/sv/ubx_nav_pvt_frame_parser_unit_tb.sv -----
// Self-checking testbench for the UBX navigation frame parser unit: serial byte
// driver, result monitor with its own frame tracker, and a stall watchdog.
// Depends on ubxp_pkg, ubxp_if and the RTL of ubx_nav_pvt_frame_parser_unit.
module ubx_nav_pvt_frame_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ubxp_pkg::*;

  // A stuck run shows up as a long stretch of cycles without a single beat
  // on either channel. The longest legitimate quiet stretch is a sender gap,
  // a receiver stall, or the short settling pauses.
  localparam int QuietLimit = 1000;
  localparam int SettleCycles = 4;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ubxp_rx_if rx_ch();
  ubxp_utc_if utc_ch();

  ubx_nav_pvt_frame_parser_unit u_top (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .utc(utc_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bytes waiting to be sent, and UTC reports the tracker says must arrive.
  logic [7:0] serial_bytes[$];
  ubxp_utc_t utc_reports_due[$];

  int error_count = 0;
  int quiet_cycles = 0;
  int frame_bytes = 0;

  // Settings as the stimulus generator knows them; used to decide whether a
  // frame is abandoned after its length field.
  logic [7:0] stim_class;
  logic [7:0] stim_id;
  logic [LengthW-1:0] stim_length;

  // Running Fletcher sums of the frame being built.
  logic [7:0] build_a;
  logic [7:0] build_b;

  // ---------------------------------------------------------------------------
  // Frame tracker. It follows every accepted byte with its own copy of the
  // registers and of the parser state, and queues the UTC report a frame must
  // produce when its checksum and its class, id and length all match.
  // ---------------------------------------------------------------------------
  logic [7:0] cur_class;
  logic [7:0] cur_id;
  logic [LengthW-1:0] cur_length;

  ubxp_phase_t hunt_phase;
  logic [7:0] seen_class;
  logic [7:0] seen_id;
  logic [15:0] seen_len;
  logic [9:0] pay_pos;
  logic [7:0] fl_a;
  logic [7:0] fl_b;
  logic [7:0] rx_ck_a;
  logic [7:0] cap[CapCount];

  task automatic fold_sum(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  task automatic track_frame_byte(input logic [7:0] b);
    ubxp_utc_t rep;
    case (hunt_phase)
      PH_SYNC2: begin
        // Anything but the second sync byte, even another first sync byte,
        // sends the parser back to hunting.
        if (b == SyncSecond) begin
          fl_a = 8'h00;
          fl_b = 8'h00;
          hunt_phase = PH_CLASS;
        end else begin
          hunt_phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        seen_class = b;
        fold_sum(b);
        hunt_phase = PH_ID;
      end
      PH_ID: begin
        seen_id = b;
        fold_sum(b);
        hunt_phase = PH_LEN1;
      end
      PH_LEN1: begin
        seen_len = {8'h00, b};
        fold_sum(b);
        hunt_phase = PH_LEN2;
      end
      PH_LEN2: begin
        seen_len[15:8] = b;
        fold_sum(b);
        pay_pos = '0;
        if (seen_len > {6'd0, cur_length}) begin
          hunt_phase = PH_SYNC1;
        end else if (seen_len == 16'd0) begin
          hunt_phase = PH_CKA;
        end else begin
          hunt_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // Only payload bytes 4 to 11 are kept; the rest just feed the sums.
        if (pay_pos >= CapFirst && pay_pos < CapFirst + CapCount) begin
          cap[CapIdxW'(pay_pos - 10'(CapFirst))] = b;
        end
        fold_sum(b);
        pay_pos = pay_pos + 10'd1;
        if ({6'd0, pay_pos} >= seen_len) begin
          hunt_phase = PH_CKA;
        end
      end
      PH_CKA: begin
        rx_ck_a = b;
        hunt_phase = PH_CKB;
      end
      PH_CKB: begin
        if (rx_ck_a == fl_a && b == fl_b && seen_class == cur_class &&
            seen_id == cur_id && seen_len == {6'd0, cur_length}) begin
          rep.year = {cap[1], cap[0]};
          rep.month = cap[2];
          rep.day = cap[3];
          rep.hour = cap[4];
          rep.minute = cap[5];
          rep.second = cap[6];
          rep.date_valid = cap[7][0];
          rep.time_valid = cap[7][1];
          rep.fully_resolved = cap[7][2];
          rep.utc_valid = cap[7][0] & cap[7][1];
          utc_reports_due.push_back(rep);
        end
        hunt_phase = PH_SYNC1;
      end
      default: begin
        if (b == SyncFirst) begin
          hunt_phase = PH_SYNC2;
        end else begin
          hunt_phase = PH_SYNC1;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. It sends in bursts of random length separated by random
  // gaps; about a quarter of the bursts are followed by no gap at all, so
  // long back-to-back stretches occur as well.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (gap_left > 0) begin
        rx_ch.valid <= 1'b0;
        gap_left--;
      end else if (serial_bytes.size() > 0) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= serial_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Ready walks through a 32-bit pattern that is redrawn at
  // each wrap. One draw in three is all ones; bit 0 is always set, so a stall
  // never lasts past the next wrap.
  // ---------------------------------------------------------------------------
  logic [31:0] stall_pat = 32'hFFFF_FFFF;
  int stall_idx = 0;

  always @(posedge clk) begin
    if (rst) begin
      utc_ch.ready <= 1'b0;
    end else begin
      utc_ch.ready <= stall_pat[stall_idx];
      if (stall_idx == 31) begin
        stall_idx = 0;
        stall_pat = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom() | 32'h1);
      end else begin
        stall_idx++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each edge it applies a register write to the tracker's copy,
  // checks a UTC beat against the oldest due report, and feeds an accepted
  // byte to the tracker. The result of a byte comes out of a register after the
  // byte's own edge, so checking before tracking never pairs a beat with its own byte.
  // ---------------------------------------------------------------------------
  ubxp_utc_t due;

  always @(posedge clk) begin
    if (rst) begin
      cur_class = ResetWantClass;
      cur_id = ResetWantId;
      cur_length = ResetWantLength;
      hunt_phase = PH_SYNC1;
      seen_class = '0;
      seen_id = '0;
      seen_len = '0;
      pay_pos = '0;
      fl_a = '0;
      fl_b = '0;
      rx_ck_a = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CfgWantClass: cur_class = cfg_data[7:0];
          CfgWantId: cur_id = cfg_data[7:0];
          CfgWantLength: cur_length = cfg_data;
          default: ;
        endcase
      end
      if (utc_ch.valid && utc_ch.ready) begin
        if (utc_reports_due.size() == 0) begin
          $display("%0t: UTC beat with no report due, expected none, actual year %0h",
                   $time, utc_ch.year);
          error_count++;
        end else begin
          due = utc_reports_due.pop_front();
          compare_field("year", due.year, utc_ch.year);
          compare_field("month", due.month, utc_ch.month);
          compare_field("day", due.day, utc_ch.day);
          compare_field("hour", due.hour, utc_ch.hour);
          compare_field("minute", due.minute, utc_ch.minute);
          compare_field("second", due.second, utc_ch.second);
          compare_field("date_valid", due.date_valid, utc_ch.date_valid);
          compare_field("time_valid", due.time_valid, utc_ch.time_valid);
          compare_field("fully_resolved", due.fully_resolved, utc_ch.fully_resolved);
          compare_field("utc_valid", due.utc_valid, utc_ch.utc_valid);
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        track_frame_byte(rx_ch.rx_byte);
      end
      if ((rx_ch.valid && rx_ch.ready) || (utc_ch.valid && utc_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("%0t: no beat for %0d cycles, run abandoned", $time, QuietLimit);
    $display("ubx_nav_pvt_frame_parser_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Those that push bytes are entered and left just after a falling
  // edge, so queue pushes never share a time step with the driver's pops.
  // ---------------------------------------------------------------------------
  task automatic put_summed(input logic [7:0] b);
    serial_bytes.push_back(b);
    build_a = build_a + b;
    build_b = build_b + build_a;
  endtask

  // Queues one frame. The date and time bytes come from fld, byte k of fld
  // going to payload byte 4 + k, so fld[63:56] is the flags byte. A declared
  // length above the current setting is cut off after the length field, as
  // the parser abandons such a frame there. corrupt 1 or 2 spoils the first
  // or the second checksum byte.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] dlen, input logic [63:0] fld,
                            input int corrupt);
    int k;
    logic [7:0] b;
    serial_bytes.push_back(SyncFirst);
    serial_bytes.push_back(SyncSecond);
    build_a = 8'h00;
    build_b = 8'h00;
    put_summed(cls);
    put_summed(id);
    put_summed(dlen[7:0]);
    put_summed(dlen[15:8]);
    frame_bytes += 6;
    if (dlen <= {6'd0, stim_length}) begin
      for (k = 0; k < dlen; k++) begin
        if (k >= CapFirst && k < CapFirst + CapCount) begin
          b = fld[8*(k-CapFirst) +: 8];
        end else begin
          b = 8'($urandom());
        end
        put_summed(b);
      end
      serial_bytes.push_back((corrupt == 1) ? build_a ^ 8'($urandom_range(1, 255)) : build_a);
      serial_bytes.push_back((corrupt == 2) ? build_b ^ 8'($urandom_range(1, 255)) : build_b);
      frame_bytes += dlen + 2;
    end
  endtask

  task automatic wait_drained;
    while (serial_bytes.size() != 0 || rx_ch.valid || utc_reports_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Brings the parser back to hunting with nothing in flight: any partial
  // frame is pushed through with filler bytes, and a few extra cycles allow
  // the last byte to settle before the registers change.
  task automatic settle_parser;
    wait_drained();
    while (hunt_phase != PH_SYNC1) begin
      serial_bytes.push_back(8'h00);
      wait_drained();
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic configure(input logic [7:0] cls, input logic [7:0] id,
                           input logic [LengthW-1:0] len);
    write_reg(CfgWantClass, {2'b00, cls});
    write_reg(CfgWantId, {2'b00, id});
    write_reg(CfgWantLength, len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    stim_class = cls;
    stim_id = id;
    stim_length = len;
  endtask

  // One random item of the random part. Most are well-formed matching frames
  // with random content; the rest are spoiled checksums, foreign class or id,
  // short or oversized lengths, line noise and broken sync pairs.
  task automatic random_item;
    int pick;
    int n;
    logic [7:0] b;
    logic [15:0] dlen;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_frame(stim_class, stim_id, {6'd0, stim_length}, {$urandom(), $urandom()}, 0);
    end else if (pick < 78) begin
      send_frame(stim_class, stim_id, {6'd0, stim_length}, {$urandom(), $urandom()},
                 $urandom_range(1, 2));
    end else if (pick < 83) begin
      if ($urandom_range(0, 1) == 0) begin
        send_frame(stim_class ^ 8'($urandom_range(1, 255)), stim_id, {6'd0, stim_length},
                   {$urandom(), $urandom()}, 0);
      end else begin
        send_frame(stim_class, stim_id ^ 8'($urandom_range(1, 255)), {6'd0, stim_length},
                   {$urandom(), $urandom()}, 0);
      end
    end else if (pick < 88) begin
      dlen = 16'($urandom_range(0, stim_length - 1));
      send_frame(stim_class, stim_id, dlen, {$urandom(), $urandom()}, 0);
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) == 0) begin
        dlen = 16'($urandom_range(stim_length + 1, stim_length + 4));
      end else begin
        dlen = 16'($urandom_range(stim_length + 1, 16'hFFFF));
      end
      send_frame(stim_class, stim_id, dlen, {$urandom(), $urandom()}, 0);
    end else if (pick < 96) begin
      n = $urandom_range(1, 6);
      repeat (n) serial_bytes.push_back(8'($urandom()));
    end else begin
      serial_bytes.push_back(SyncFirst);
      b = ($urandom_range(0, 1) == 0) ? SyncFirst : 8'($urandom());
      if (b == SyncSecond) begin
        b = 8'h00;
      end
      serial_bytes.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int rand_cls;
  int len_pick;

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    utc_ch.ready = 1'b0;
    stim_class = ResetWantClass;
    stim_id = ResetWantId;
    stim_length = ResetWantLength;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With the reset settings a full 92-byte frame with every date, time and
    // flag bit set must be reported. It also fills all captured bytes, so a
    // later short frame never shows a byte that was never received.
    send_frame(ResetWantClass, ResetWantId, 16'd92, '1, 0);
    settle_parser();

    // Smallest normal length, lowest class, highest id.
    configure(8'h00, 8'hFF, 10'd12);
    send_frame(8'h00, 8'hFF, 16'd12, '0, 0);
    send_frame(8'h00, 8'hFF, 16'd12, {8'h03, 24'($urandom()), $urandom()}, 0);
    send_frame(8'h00, 8'hFF, 16'd12, {8'h01, 24'($urandom()), $urandom()}, 0);
    send_frame(8'h00, 8'hFF, 16'd12, {8'h06, 24'($urandom()), $urandom()}, 0);
    // Spoiled checksum bytes, foreign class and id, and a short payload all
    // leave the output silent.
    send_frame(8'h00, 8'hFF, 16'd12, {$urandom(), $urandom()}, 1);
    send_frame(8'h00, 8'hFF, 16'd12, {$urandom(), $urandom()}, 2);
    send_frame(8'h01, 8'hFF, 16'd12, {$urandom(), $urandom()}, 0);
    send_frame(8'h00, 8'hFE, 16'd12, {$urandom(), $urandom()}, 0);
    send_frame(8'h00, 8'hFF, 16'd11, {$urandom(), $urandom()}, 0);
    // A zero length goes straight to the checksum bytes.
    send_frame(8'h00, 8'hFF, 16'd0, {$urandom(), $urandom()}, 0);
    // Declared lengths just and far above the setting abandon the frame; a
    // good frame must still be found right behind them.
    send_frame(8'h00, 8'hFF, 16'd13, {$urandom(), $urandom()}, 0);
    send_frame(8'h00, 8'hFF, 16'hFFFF, {$urandom(), $urandom()}, 0);
    send_frame(8'h00, 8'hFF, 16'd12, {$urandom(), $urandom()}, 0);
    // A repeated first sync byte in the second sync slot returns to hunting,
    // so the frame that follows it is lost.
    serial_bytes.push_back(SyncFirst);
    send_frame(8'h00, 8'hFF, 16'd12, {$urandom(), $urandom()}, 0);
    settle_parser();
    serial_bytes.push_back(SyncFirst);
    serial_bytes.push_back(8'h00);
    send_frame(8'h00, 8'hFF, 16'd12, {$urandom(), $urandom()}, 0);
    settle_parser();

    // Highest class, lowest id and the top of the length register: a declared
    // length one above it is abandoned, and a shorter frame is not reported.
    configure(8'hFF, 8'h00, 10'd1023);
    send_frame(8'hFF, 8'h00, 16'd1024, {$urandom(), $urandom()}, 0);
    send_frame(8'hFF, 8'h00, 16'd40, {$urandom(), $urandom()}, 0);
    settle_parser();

    // The payload runs far past byte 11 and only bytes 4 to 11 may be
    // reported.
    configure(8'hFF, 8'h00, 10'd40);
    send_frame(8'hFF, 8'h00, 16'd40, {$urandom(), $urandom()}, 0);
    send_frame(8'hFF, 8'h00, 16'd20, {$urandom(), $urandom()}, 0);
    settle_parser();

    // A length below twelve reports the newly captured bytes mixed with the
    // ones left over from the last long frame above.
    configure(ResetWantClass, ResetWantId, 10'd8);
    send_frame(ResetWantClass, ResetWantId, 16'd8, {$urandom(), $urandom()}, 0);
    send_frame(ResetWantClass, ResetWantId, 16'd1023, {$urandom(), $urandom()}, 0);
    send_frame(ResetWantClass, ResetWantId, 16'd8, {$urandom(), $urandom()}, 0);
    settle_parser();

    // Random part: short settings dominate so that results come often; the
    // smallest normal length, twelve, turns up now and then.
    while (frame_bytes < 1000) begin
      rand_cls = $urandom_range(0, 255);
      len_pick = $urandom_range(0, 99);
      if (len_pick < 15) begin
        configure(8'(rand_cls), 8'($urandom_range(0, 255)), 10'd12);
      end else if (len_pick < 80) begin
        configure(8'(rand_cls), 8'($urandom_range(0, 255)), 10'($urandom_range(13, 24)));
      end else begin
        configure(8'(rand_cls), 8'($urandom_range(0, 255)), 10'($urandom_range(25, 100)));
      end
      repeat ($urandom_range(4, 10)) random_item();
      settle_parser();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (utc_reports_due.size() != 0) begin
      $display("%0t: %0d UTC reports expected, actual none", $time, utc_reports_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ubx_nav_pvt_frame_parser_unit_tb: PASS");
    end else begin
      $display("ubx_nav_pvt_frame_parser_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
